FILE: src/olist_pkg.sv
// Shared types for the ordered list engine: action codes, result status codes
// and the sequencer states. No dependencies.
package olist_pkg;

  // Action carried by one input word.
  typedef enum logic [2:0] {
    ACT_APPEND  = 3'd0,
    ACT_INSERT  = 3'd1,
    ACT_REMOVE  = 3'd2,
    ACT_POP     = 3'd3,
    ACT_CLEAR   = 3'd4,
    ACT_INDEX   = 3'd5,
    ACT_COUNT   = 3'd6,
    ACT_REVERSE = 3'd7
  } action_t;

  // Status returned with every result word.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_RANGE     = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_REV_RD_HI,
    S_REV_WR_LO,
    S_REV_WR_HI
  } state_t;

endpackage

FILE: src/ordered_list_engine_unit.sv
// Ordered list engine: a list of signed words kept in one single-port-write,
// single-port-read memory and walked by a small sequencer.
// Depends on olist_pkg.
//
//   Channel  Handshake           Ports
//   -------  ------------------  ---------------------------------------------
//   input    start & !busy       action, value, position, end_position
//   result   done (one cycle)    status, found_index, match_count, length
//
// Append, clear and every rejected action finish as they are taken; done follows on the
// next cycle. Index-of, count and remove scan one entry per cycle, and insert, pop
// and remove then move one entry per cycle. Reverse swaps each pair through the
// S_REV_RD_HI, S_REV_WR_LO and S_REV_WR_HI states. The one memory read port and
// one write port set these rates.
// rst is synchronous and empties the list; entry contents are not cleared.
// The receiver cannot stall: a result word is shown for exactly one cycle, and
// a new start may be taken in the same cycle that done is high.
module ordered_list_engine_unit #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  olist_pkg::action_t    action,
  input  logic signed [31:0]    value,
  input  logic        [5:0]     position,
  input  logic        [5:0]     end_position,
  output logic                  done,
  output olist_pkg::status_t    status,
  output logic        [5:0]     found_index,
  output logic        [6:0]     match_count,
  output logic        [6:0]     length
);
  import olist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  // Entry store.
  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rdata;
  logic                 rd_en;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;

  // Sequencer state and working registers.
  state_t               state, state_next;
  action_t              act, act_next;
  logic [WORD_BITS-1:0] val, val_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        rem, rem_next;
  logic [CW-1:0]        mcount, mcount_next;
  logic [AW-1:0]        rp, rp_next;
  logic                 pend, pend_next;
  logic [AW-1:0]        pend_addr, pend_addr_next;
  logic [AW-1:0]        lo, lo_next;
  logic [AW-1:0]        hi, hi_next;
  logic [WORD_BITS-1:0] hold, hold_next;
  logic                 done_next;
  status_t              status_next;
  logic [5:0]           found_index_next;
  logic [6:0]           match_count_next;
  logic [6:0]           length_next;

  // Helpers for the finishing step and width changes.
  logic                 fin;
  status_t              fin_status;
  logic [AW-1:0]        fin_found;
  logic [63:0]          val_ext;
  logic [WORD_BITS-1:0] fit_val;
  logic [XW-1:0]        pos_x, endp_x, count_x, found_x, mcount_x, length_x;
  logic                 is_full;
  logic                 hit;
  logic [AW-1:0]        lo_inc, hi_dec;

  // The incoming value is sign-extended and then kept in WORD_BITS bits.
  assign val_ext = {{32{value[31]}}, value};
  assign fit_val = val_ext[WORD_BITS-1:0];
  assign pos_x   = XW'(position);
  assign endp_x  = XW'(end_position);
  assign count_x = XW'(count);
  assign is_full = (count_x >= XW'(CAPACITY));
  assign hit     = pend && (rdata == val);
  assign lo_inc  = lo + AW'(1);
  assign hi_dec  = hi - AW'(1);

  assign busy = (state != S_IDLE);

  // Memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    act         <= act_next;
    val         <= val_next;
    rem         <= rem_next;
    mcount      <= mcount_next;
    rp          <= rp_next;
    pend_addr   <= pend_addr_next;
    lo          <= lo_next;
    hi          <= hi_next;
    hold        <= hold_next;
    status      <= status_next;
    found_index <= found_index_next;
    match_count <= match_count_next;
    length      <= length_next;
  end

  // Next state, memory control and finishing step.
  always_comb begin
    state_next     = state;
    act_next       = act;
    val_next       = val;
    count_next     = count;
    rem_next       = rem;
    mcount_next    = mcount;
    rp_next        = rp;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    lo_next        = lo;
    hi_next        = hi;
    hold_next      = hold;
    rd_en          = 1'b0;
    raddr          = rp;
    we             = 1'b0;
    waddr          = lo;
    wdata          = rdata;
    fin            = 1'b0;
    fin_status     = STAT_OK;
    fin_found      = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          act_next    = action;
          val_next    = fit_val;
          mcount_next = '0;
          pend_next   = 1'b0;
          unique case (action)
            ACT_APPEND: begin
              fin = 1'b1;
              if (is_full) begin
                fin_status = STAT_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = fit_val;
                count_next = count + CW'(1);
              end
            end
            ACT_INSERT: begin
              if (is_full) begin
                fin        = 1'b1;
                fin_status = STAT_FULL;
              end else if (pos_x > count_x) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else begin
                // Move entries up from the top down to the insert position.
                lo_next    = pos_x[AW-1:0];
                rp_next    = count[AW-1:0] - AW'(1);
                rem_next   = count - pos_x[CW-1:0];
                state_next = S_SHIFT;
              end
            end
            ACT_POP: begin
              if (pos_x >= count_x) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else begin
                rp_next    = pos_x[AW-1:0] + AW'(1);
                rem_next   = count - pos_x[CW-1:0] - CW'(1);
                state_next = S_SHIFT;
              end
            end
            ACT_CLEAR: begin
              fin        = 1'b1;
              count_next = '0;
            end
            ACT_REVERSE: begin
              if (endp_x >= count_x) begin
                fin        = 1'b1;
                fin_status = STAT_RANGE;
              end else if (pos_x >= endp_x) begin
                fin = 1'b1;
              end else begin
                lo_next    = pos_x[AW-1:0];
                hi_next    = endp_x[AW-1:0];
                rd_en      = 1'b1;
                raddr      = pos_x[AW-1:0];
                state_next = S_REV_RD_HI;
              end
            end
            ACT_REMOVE, ACT_INDEX, ACT_COUNT: begin
              rp_next    = '0;
              rem_next   = count;
              state_next = S_SCAN;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Read one entry per cycle and compare it on the next.
      S_SCAN: begin
        if (hit && act != ACT_COUNT) begin
          if (act == ACT_INDEX) begin
            fin       = 1'b1;
            fin_found = pend_addr;
          end else begin
            // Remove: close the gap left by the first match.
            rp_next    = pend_addr + AW'(1);
            rem_next   = count - CW'(pend_addr) - CW'(1);
            pend_next  = 1'b0;
            state_next = S_SHIFT;
          end
        end else begin
          if (hit) begin
            mcount_next = mcount + CW'(1);
          end
          if (rem != '0) begin
            rd_en          = 1'b1;
            raddr          = rp;
            pend_next      = 1'b1;
            pend_addr_next = rp;
            rp_next        = rp + AW'(1);
            rem_next       = rem - CW'(1);
          end else if (pend) begin
            pend_next = 1'b0;
          end else begin
            fin        = 1'b1;
            fin_status = (act == ACT_COUNT) ? STAT_OK : STAT_NOT_FOUND;
          end
        end
      end

      // Move entries by one place: up for insert, down for pop and remove.
      S_SHIFT: begin
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr;
          wdata = rdata;
        end
        if (rem != '0) begin
          rd_en     = 1'b1;
          raddr     = rp;
          pend_next = 1'b1;
          rem_next  = rem - CW'(1);
          if (act == ACT_INSERT) begin
            pend_addr_next = rp + AW'(1);
            rp_next        = rp - AW'(1);
          end else begin
            pend_addr_next = rp - AW'(1);
            rp_next        = rp + AW'(1);
          end
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          fin = 1'b1;
          if (act == ACT_INSERT) begin
            we         = 1'b1;
            waddr      = lo;
            wdata      = val;
            count_next = count + CW'(1);
          end else begin
            count_next = count - CW'(1);
          end
        end
      end

      // The low word is in the read register; fetch the high word.
      S_REV_RD_HI: begin
        hold_next  = rdata;
        rd_en      = 1'b1;
        raddr      = hi;
        state_next = S_REV_WR_LO;
      end

      S_REV_WR_LO: begin
        we         = 1'b1;
        waddr      = lo;
        wdata      = rdata;
        state_next = S_REV_WR_HI;
      end

      // Finish the swap and start the next pair if one remains.
      S_REV_WR_HI: begin
        we      = 1'b1;
        waddr   = hi;
        wdata   = hold;
        lo_next = lo_inc;
        hi_next = hi_dec;
        if (lo_inc < hi_dec) begin
          rd_en      = 1'b1;
          raddr      = lo_inc;
          state_next = S_REV_RD_HI;
        end else begin
          fin = 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
    end
  end

  // Result word, shown for one cycle after the finishing step.
  assign found_x  = XW'(fin_found);
  assign mcount_x = XW'(mcount_next);
  assign length_x = XW'(count_next);

  always_comb begin
    done_next        = fin;
    status_next      = status;
    found_index_next = found_index;
    match_count_next = match_count;
    length_next      = length;
    if (fin) begin
      status_next      = fin_status;
      found_index_next = found_x[5:0];
      match_count_next = (act_next == ACT_COUNT) ? mcount_x[6:0] : 7'd0;
      length_next      = length_x[6:0];
    end
  end

endmodule

FILE: bench/ordered_list_engine_unit_tb.sv
// Self-checking testbench for ordered_list_engine_unit: a mirror of the list predicts every
// result word, which is checked against the block's output. Depends on olist_pkg and the RTL.
module ordered_list_engine_unit_tb;
  import olist_pkg::*;

  localparam int LIST_DEPTH  = 64;
  localparam int ITEM_GOAL   = 1050;
  localparam int TAIL_CYCLES = 150;
  localparam int CYCLE_LIMIT = 1000000;

  // Reply fields expected for one input word.
  typedef struct {
    status_t     status;
    logic [5:0]  found;
    logic [6:0]  hits;
    logic [6:0]  len;
  } list_reply_t;

  // Mirror of the list contents plus the replies still owed by the block.
  class list_mirror;
    logic [31:0]  words [LIST_DEPTH];
    int           fill;
    int           faults;
    list_reply_t  awaited_replies [$];

    function new();
      fill = 0;
      faults = 0;
    endfunction

    function int first_hit(logic [31:0] val);
      int i;
      for (i = 0; i < fill; i++) begin
        if (words[i] == val) return i;
      end
      return -1;
    endfunction

    // Apply one accepted word to the mirror and queue the reply it earns.
    function void note_word(action_t act, logic [31:0] val, logic [5:0] pos,
                            logic [5:0] endp);
      list_reply_t r;
      int i;
      int k;
      int lo;
      int hi;
      int n;
      logic [31:0] t;
      r.status = STAT_OK;
      r.found = '0;
      r.hits = '0;
      case (act)
        ACT_APPEND: begin
          if (fill >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            words[fill] = val;
            fill++;
          end
        end
        ACT_INSERT: begin
          // Fullness wins over a bad position.
          if (fill >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else if (int'(pos) > fill) begin
            r.status = STAT_RANGE;
          end else begin
            for (i = fill; i > int'(pos); i--) words[i] = words[i-1];
            words[pos] = val;
            fill++;
          end
        end
        ACT_REMOVE: begin
          k = first_hit(val);
          if (k < 0) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            for (i = k; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        ACT_POP: begin
          if (int'(pos) >= fill) begin
            r.status = STAT_RANGE;
          end else begin
            for (i = int'(pos); i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        ACT_CLEAR: begin
          fill = 0;
        end
        ACT_INDEX: begin
          k = first_hit(val);
          if (k < 0) r.status = STAT_NOT_FOUND;
          else r.found = 6'(k);
        end
        ACT_COUNT: begin
          n = 0;
          for (i = 0; i < fill; i++) begin
            if (words[i] == val) n++;
          end
          r.hits = 7'(n);
        end
        default: begin
          // Reverse range; a low end at or past the high end leaves the list alone.
          if (int'(endp) >= fill) begin
            r.status = STAT_RANGE;
          end else begin
            lo = int'(pos);
            hi = int'(endp);
            while (lo < hi) begin
              t = words[lo];
              words[lo] = words[hi];
              words[hi] = t;
              lo++;
              hi--;
            end
          end
        end
      endcase
      r.len = 7'(fill);
      awaited_replies.push_back(r);
    endfunction

    // Compare one result word with the oldest reply owed.
    function void check_word(status_t st, logic [5:0] fi, logic [6:0] mc, logic [6:0] ln);
      list_reply_t r;
      if (awaited_replies.size() == 0) begin
        $display("%0t: result word with none expected, status %0d length %0d",
                 $time, st, ln);
        faults++;
        return;
      end
      r = awaited_replies.pop_front();
      if (st !== r.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, r.status, st);
        faults++;
      end
      if (fi !== r.found) begin
        $display("%0t: found_index mismatch, expected %0d actual %0d", $time, r.found, fi);
        faults++;
      end
      if (mc !== r.hits) begin
        $display("%0t: match_count mismatch, expected %0d actual %0d", $time, r.hits, mc);
        faults++;
      end
      if (ln !== r.len) begin
        $display("%0t: length mismatch, expected %0d actual %0d", $time, r.len, ln);
        faults++;
      end
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    function logic [31:0] sample_entry();
      return words[$urandom_range(0, fill - 1)];
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  action_t            action = ACT_APPEND;
  logic signed [31:0] value = '0;
  logic        [5:0]  position = '0;
  logic        [5:0]  end_position = '0;
  logic               done;
  status_t            status;
  logic        [5:0]  found_index;
  logic        [6:0]  match_count;
  logic        [6:0]  length;

  list_mirror shadow = new();
  int         cycles = 0;
  bit         quiet = 1'b0;
  int         sent = 0;

  ordered_list_engine_unit dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .value        (value),
    .position     (position),
    .end_position (end_position),
    .done         (done),
    .status       (status),
    .found_index  (found_index),
    .match_count  (match_count),
    .length       (length)
  );

  always #1 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Every result word is shown for one cycle only, so it is checked at that edge.
  always @(posedge clk) begin
    if (!rst && done) shadow.check_word(status, found_index, match_count, length);
  end

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic issue_word(action_t act, logic [31:0] val, logic [5:0] pos,
                            logic [5:0] endp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    value <= val;
    position <= pos;
    end_position <= endp;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow.note_word(act, val, pos, endp);
    sent++;
  endtask

  // Hold off the next word until every owed result has come back.
  task automatic settle_list();
    start <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  // Values lean toward stored ones and extremes so that searches hit.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && shadow.fill > 0) return shadow.sample_entry();
    if (roll < 70) begin
      case ($urandom_range(0, 5))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hFFFF_FFFF;
        3: return 32'h7FFF_FFFF;
        4: return 32'h8000_0000;
        default: return 32'(int'($urandom_range(0, 9)));
      endcase
    end
    return $urandom;
  endfunction

  // Action mix per phase: grow, shrink, even mix, or flood with one value.
  function automatic action_t draw_action(int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: begin
        if (roll < 45) return ACT_APPEND;
        if (roll < 80) return ACT_INSERT;
        if (roll < 85) return ACT_INDEX;
        if (roll < 90) return ACT_COUNT;
        if (roll < 94) return ACT_REMOVE;
        if (roll < 97) return ACT_POP;
        return ACT_REVERSE;
      end
      1: begin
        if (roll < 33) return ACT_REMOVE;
        if (roll < 66) return ACT_POP;
        if (roll < 74) return ACT_INDEX;
        if (roll < 82) return ACT_COUNT;
        if (roll < 91) return ACT_REVERSE;
        if (roll < 94) return ACT_APPEND;
        if (roll < 98) return ACT_INSERT;
        return ACT_CLEAR;
      end
      2: begin
        if (roll < 2) return ACT_CLEAR;
        case ($urandom_range(0, 6))
          0: return ACT_APPEND;
          1: return ACT_INSERT;
          2: return ACT_REMOVE;
          3: return ACT_POP;
          4: return ACT_INDEX;
          5: return ACT_COUNT;
          default: return ACT_REVERSE;
        endcase
      end
      default: begin
        if (roll < 60) return ACT_APPEND;
        if (roll < 80) return ACT_INSERT;
        if (roll < 90) return ACT_COUNT;
        if (roll < 95) return ACT_REMOVE;
        return ACT_INDEX;
      end
    endcase
  endfunction

  // Positions mostly land inside the list, sometimes anywhere in the field.
  function automatic logic [5:0] pick_slot(int lim);
    if (lim >= 0 && $urandom_range(0, 99) < 80) return 6'($urandom_range(0, lim));
    return 6'($urandom_range(0, 63));
  endfunction

  initial begin
    int          mode;
    int          run;
    logic [31:0] flood_val;
    logic [31:0] val;
    logic [5:0]  pos;
    logic [5:0]  endp;
    action_t     act;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: reverse, pop, remove, index, count and insert on an empty list, field extremes, edge positions.
    issue_word(ACT_REVERSE, 32'h0, 6'd0, 6'd0);
    issue_word(ACT_POP, 32'h0, 6'd0, 6'd0);
    issue_word(ACT_REMOVE, 32'h0, 6'd0, 6'd0);
    issue_word(ACT_INDEX, 32'h0, 6'd0, 6'd0);
    issue_word(ACT_COUNT, 32'h0, 6'd0, 6'd0);
    issue_word(ACT_INSERT, 32'h7FFF_FFFF, 6'd1, 6'd0);
    issue_word(ACT_INSERT, 32'h7FFF_FFFF, 6'd0, 6'd63);
    issue_word(ACT_APPEND, 32'h8000_0000, 6'd63, 6'd63);
    quiet = 1'b1;
    issue_word(ACT_APPEND, 32'hFFFF_FFFF, 6'd0, 6'd0);
    issue_word(ACT_INSERT, 32'h0, 6'd3, 6'd0);
    issue_word(ACT_INSERT, 32'h5555_AAAA, 6'd1, 6'd0);
    issue_word(ACT_INSERT, 32'h8000_0000, 6'd63, 6'd0);
    issue_word(ACT_INDEX, 32'h8000_0000, 6'd0, 6'd0);
    issue_word(ACT_COUNT, 32'h8000_0000, 6'd0, 6'd0);
    quiet = 1'b0;
    issue_word(ACT_REMOVE, 32'h1234_5678, 6'd0, 6'd0);
    issue_word(ACT_REMOVE, 32'hFFFF_FFFF, 6'd0, 6'd0);
    issue_word(ACT_POP, 32'h0, 6'd0, 6'd0);
    issue_word(ACT_POP, 32'h0, 6'd5, 6'd0);
    issue_word(ACT_REVERSE, 32'h0, 6'd0, 6'd2);
    issue_word(ACT_REVERSE, 32'h0, 6'd2, 6'd0);
    issue_word(ACT_REVERSE, 32'h0, 6'd1, 6'd1);
    issue_word(ACT_REVERSE, 32'h0, 6'd0, 6'd63);
    issue_word(ACT_CLEAR, 32'h0, 6'd0, 6'd0);
    settle_list();

    // Random phases; growth and flood phases drive the list to full and past it.
    while (sent < ITEM_GOAL) begin
      mode = $urandom_range(0, 3);
      quiet = ($urandom_range(0, 3) == 0);
      run = $urandom_range(10, 90);
      flood_val = pick_value();
      repeat (run) begin
        act = draw_action(mode);
        val = (mode == 3) ? flood_val : pick_value();
        pos = 6'($urandom_range(0, 63));
        endp = 6'($urandom_range(0, 63));
        case (act)
          ACT_INSERT: pos = pick_slot(shadow.fill);
          ACT_POP: pos = pick_slot(shadow.fill - 1);
          ACT_REVERSE: begin
            if (shadow.fill > 0 && $urandom_range(0, 99) < 85) begin
              endp = 6'($urandom_range(0, shadow.fill - 1));
              if ($urandom_range(0, 99) < 80) pos = 6'($urandom_range(0, endp));
            end
          end
          default: ;
        endcase
        issue_word(act, val, pos, endp);
      end
      if ($urandom_range(0, 4) == 0) settle_list();
    end

    // Wait for the last results, then a quiet tail for anything stray.
    settle_list();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.faults == 0 && shadow.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/olist_pkg.sv
src/ordered_list_engine_unit.sv
bench/ordered_list_engine_unit_tb.sv
